@@ hw/rtl/svls_pkg.sv @@
// Shared types, constants and helper functions for the sprite light shading block.
package svls_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int MAX_LIGHT_LIMIT = 11;
  localparam int ONE_Q           = 1 << FRAC_BITS;

  localparam int VEC_W    = 16;
  localparam int COLOR_W  = 15;
  localparam int COUNT_W  = 4;
  localparam int SUM_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Sum of three 16x16 signed products.
  localparam int ACC_W   = 2 * VEC_W + 2;
  localparam int DOT_W   = ACC_W - FRAC_BITS;
  localparam int S_W     = ((DOT_W > VEC_W) ? DOT_W : VEC_W) + 1;
  // Clamped strength spans -ONE..ONE.
  localparam int SC_W    = FRAC_BITS + 2;
  localparam int MUL_A_W = (S_W > SC_W) ? S_W : SC_W;
  localparam int MUL_B_W = VEC_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SUM_MAX = (1 << (SUM_W - 1)) - 1;
  localparam int SUM_MIN = -(1 << (SUM_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X      = 3'd0,
    REG_NORMAL_Y      = 3'd1,
    REG_NORMAL_Z      = 3'd2,
    REG_AMBIENT_RED   = 3'd3,
    REG_AMBIENT_GREEN = 3'd4,
    REG_AMBIENT_BLUE  = 3'd5,
    REG_AMBIENT_ALPHA = 3'd6,
    REG_MAX_LIGHTS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                     has_light;
    logic signed [VEC_W-1:0]  dir_x;
    logic signed [VEC_W-1:0]  dir_y;
    logic signed [VEC_W-1:0]  dir_z;
    logic signed [VEC_W-1:0]  bias;
    logic signed [VEC_W-1:0]  lit_gain;
    logic signed [VEC_W-1:0]  dark_gain;
    logic [COLOR_W-1:0]       light_red;
    logic [COLOR_W-1:0]       light_green;
    logic [COLOR_W-1:0]       light_blue;
    logic                     uses_ambient;
    logic                     last_light;
  } light_t;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic [7:0] alpha_byte;
  } pixel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT0,
    ST_DOT1,
    ST_DOT2,
    ST_DSUM,
    ST_GAIN,
    ST_CLAMP,
    ST_COL0,
    ST_COL1,
    ST_COL2,
    ST_CACC,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MS_DX,
    MS_DY,
    MS_DZ,
    MS_GAIN,
    MS_RED,
    MS_GREEN,
    MS_BLUE
  } mul_sel_t;

  typedef struct packed {
    logic     busy;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     s_load;
    logic     ch_add;
    logic [1:0] ch_idx;
    logic     finish;
  } ctrl_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (t > SUM_MAX) begin
      return SUM_W'(SUM_MAX);
    end else if (t < SUM_MIN) begin
      return SUM_W'(SUM_MIN);
    end
    return t[SUM_W-1:0];
  endfunction

  function automatic logic [FRAC_BITS:0] clamp_one(input logic signed [SUM_W:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > ONE_Q) begin
      return (FRAC_BITS+1)'(ONE_Q);
    end
    return v[FRAC_BITS:0];
  endfunction

  // floor(255 * v / ONE) with 255 * v done as a shift and subtract.
  function automatic logic [7:0] to_byte(input logic [FRAC_BITS:0] v);
    logic [FRAC_BITS+8:0] t;
    t = {v, 8'b0} - (FRAC_BITS+9)'(v);
    return t[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

@@ hw/rtl/svls_mul.sv @@
// Shared signed multiplier with a registered product.
module svls_mul
  import svls_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ hw/rtl/svls_ctrl.sv @@
// Sequencer that steps one light through the shared multiplier.
module svls_ctrl
  import svls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  take,
  input  logic  start_last,
  input  logic  item_last,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (take) begin
            state_next = ST_DOT0;
          end else if (start_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DOT0:  state_next = ST_DOT1;
      ST_DOT1:  state_next = ST_DOT2;
      ST_DOT2:  state_next = ST_DSUM;
      ST_DSUM:  state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_COL0;
      ST_COL0:  state_next = ST_COL1;
      ST_COL1:  state_next = ST_COL2;
      ST_COL2:  state_next = ST_CACC;
      ST_CACC:  state_next = item_last ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.busy     = (state != ST_IDLE);
    ctrl.mul_sel  = MS_DX;
    unique case (state)
      ST_IDLE:  ;
      ST_DOT0:  ctrl.mul_sel = MS_DX;
      ST_DOT1: begin
        ctrl.mul_sel  = MS_DY;
        ctrl.acc_load = 1'b1;
      end
      ST_DOT2: begin
        ctrl.mul_sel = MS_DZ;
        ctrl.acc_add = 1'b1;
      end
      ST_DSUM:  ctrl.acc_add = 1'b1;
      ST_GAIN:  ctrl.mul_sel = MS_GAIN;
      ST_CLAMP: ctrl.s_load = 1'b1;
      ST_COL0:  ctrl.mul_sel = MS_RED;
      ST_COL1: begin
        ctrl.mul_sel = MS_GREEN;
        ctrl.ch_add  = 1'b1;
        ctrl.ch_idx  = 2'd0;
      end
      ST_COL2: begin
        ctrl.mul_sel = MS_BLUE;
        ctrl.ch_add  = 1'b1;
        ctrl.ch_idx  = 2'd1;
      end
      ST_CACC: begin
        ctrl.ch_add = 1'b1;
        ctrl.ch_idx = 2'd2;
      end
      ST_FIN:   ctrl.finish = out_free;
      default:  ;
    endcase
  end

endmodule

@@ hw/rtl/sprite_vector_light_shading.sv @@
// Top level of the sprite light shading block: registers, datapath and handshakes.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  light    | in        | light_valid/stall  | light_t, one light per beat
//  pixel    | out       | pixel_valid/stall  | pixel_t, one RGBA beat/sprite
//  cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data
//
//  A light that is taken occupies the block from its accept cycle through the
//  sequencer steps DOT0 to CACC, which make seven passes through the one shared
//  multiplier (three dot terms, the gain, three color terms). An ignored or
//  empty beat is taken in the idle state and starts no steps. A last_light beat
//  adds a FIN step that loads the output register once it holds no untaken beat.
//  Reset clears the sums, the light count, the sequencer and the output valid,
//  and loads the register reset values. light_stall is high while busy.
module sprite_vector_light_shading
  import svls_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   light_valid,
  output logic                   light_stall,
  input  light_t                 light,
  output logic                   pixel_valid,
  input  logic                   pixel_stall,
  output pixel_t                 pixel,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic signed [VEC_W-1:0] normal_x, normal_y, normal_z;
  logic [COLOR_W-1:0]      ambient_red, ambient_green, ambient_blue, ambient_alpha;
  logic [COUNT_W-1:0]      max_lights;

  // Working state.
  light_t                   item;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SC_W-1:0]   strength;
  logic signed [SUM_W-1:0]  ambient_sum [3];
  logic signed [SUM_W-1:0]  extra_sum [3];
  logic [COUNT_W-1:0]       lights_taken;

  ctrl_t                    ctrl;
  logic                     start, take, out_free;
  logic [COUNT_W-1:0]       limit;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [S_W-1:0]     s_full;
  logic signed [PROD_W-1:0]  gained;
  logic signed [SUM_W-1:0]   contrib;
  pixel_t                    pixel_next;

  assign cfg_ready   = 1'b1;
  assign light_stall = ctrl.busy;
  assign start       = light_valid && !ctrl.busy;
  assign out_free    = !pixel_valid || !pixel_stall;

  // A limit above the supported count acts as that count; zero means no limit.
  assign limit = (max_lights > COUNT_W'(MAX_LIGHT_LIMIT)) ? COUNT_W'(MAX_LIGHT_LIMIT)
                                                          : max_lights;
  assign take  = light.has_light && ((limit == '0) || (lights_taken < limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x      <= '0;
      normal_y      <= '0;
      normal_z      <= VEC_W'(ONE_Q);
      ambient_red   <= '0;
      ambient_green <= '0;
      ambient_blue  <= '0;
      ambient_alpha <= COLOR_W'(ONE_Q);
      max_lights    <= COUNT_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NORMAL_X:      normal_x      <= cfg_data;
        REG_NORMAL_Y:      normal_y      <= cfg_data;
        REG_NORMAL_Z:      normal_z      <= cfg_data;
        REG_AMBIENT_RED:   ambient_red   <= cfg_data[COLOR_W-1:0];
        REG_AMBIENT_GREEN: ambient_green <= cfg_data[COLOR_W-1:0];
        REG_AMBIENT_BLUE:  ambient_blue  <= cfg_data[COLOR_W-1:0];
        REG_AMBIENT_ALPHA: ambient_alpha <= cfg_data[COLOR_W-1:0];
        REG_MAX_LIGHTS:    max_lights    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  svls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .take       (take),
    .start_last (light.last_light),
    .item_last  (item.last_light),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  // Strength before gain: floor of the dot product plus the bias.
  assign s_full = S_W'(acc >>> FRAC_BITS) + S_W'(item.bias);

  // Operand steering for the shared multiplier.
  always_comb begin
    mul_a = MUL_A_W'(strength);
    mul_b = MUL_B_W'(item.light_red);
    unique case (ctrl.mul_sel)
      MS_DX: begin
        mul_a = MUL_A_W'(item.dir_x);
        mul_b = MUL_B_W'(normal_x);
      end
      MS_DY: begin
        mul_a = MUL_A_W'(item.dir_y);
        mul_b = MUL_B_W'(normal_y);
      end
      MS_DZ: begin
        mul_a = MUL_A_W'(item.dir_z);
        mul_b = MUL_B_W'(normal_z);
      end
      MS_GAIN: begin
        mul_a = MUL_A_W'(s_full);
        // Positive strength takes the lit-side gain, the rest the dark-side gain.
        mul_b = (s_full > 0) ? MUL_B_W'(item.lit_gain) : MUL_B_W'(item.dark_gain);
      end
      MS_RED:   mul_b = $signed(MUL_B_W'(item.light_red));
      MS_GREEN: mul_b = $signed(MUL_B_W'(item.light_green));
      MS_BLUE:  mul_b = $signed(MUL_B_W'(item.light_blue));
      default: ;
    endcase
  end

  svls_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Arithmetic shifts give the floor toward minus infinity.
  assign gained  = prod >>> FRAC_BITS;
  assign contrib = SUM_W'(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (start) begin
      item <= light;
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.s_load) begin
      // Clamp the gained strength to [-1, 1].
      if (gained > PROD_W'(ONE_Q)) begin
        strength <= SC_W'(ONE_Q);
      end else if (gained < -PROD_W'(ONE_Q)) begin
        strength <= -SC_W'(ONE_Q);
      end else begin
        strength <= SC_W'(gained);
      end
    end
  end

  // Sums and light count.
  always_ff @(posedge clk) begin
    if (rst || ctrl.finish) begin
      for (int i = 0; i < 3; i++) begin
        ambient_sum[i] <= '0;
        extra_sum[i]   <= '0;
      end
      lights_taken <= '0;
    end else begin
      if (start && take && (lights_taken != '1)) begin
        lights_taken <= lights_taken + COUNT_W'(1);
      end
      if (ctrl.ch_add) begin
        if (item.uses_ambient) begin
          ambient_sum[ctrl.ch_idx] <= sat_add(ambient_sum[ctrl.ch_idx], contrib);
        end else begin
          extra_sum[ctrl.ch_idx] <= sat_add(extra_sum[ctrl.ch_idx], contrib);
        end
      end
    end
  end

  // Final color: max(sum, ambient) plus extra, clamped to [0, 1], to a byte.
  always_comb begin
    logic signed [SUM_W-1:0] amb  [3];
    logic signed [SUM_W-1:0] base [3];
    logic [7:0]              chan [3];
    amb[0] = $signed(SUM_W'(ambient_red));
    amb[1] = $signed(SUM_W'(ambient_green));
    amb[2] = $signed(SUM_W'(ambient_blue));
    for (int i = 0; i < 3; i++) begin
      base[i] = (ambient_sum[i] > amb[i]) ? ambient_sum[i] : amb[i];
      chan[i] = to_byte(clamp_one((SUM_W+1)'(base[i]) + (SUM_W+1)'(extra_sum[i])));
    end
    pixel_next.red_byte   = chan[0];
    pixel_next.green_byte = chan[1];
    pixel_next.blue_byte  = chan[2];
    pixel_next.alpha_byte = to_byte(clamp_one($signed((SUM_W+1)'(ambient_alpha))));
  end

  // Output register: hold the beat until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (ctrl.finish) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      pixel <= pixel_next;
    end
  end

endmodule

@@ tb/sv/sprite_vector_light_shading_tb.sv @@
// Self-checking testbench for the sprite light shading block.
module sprite_vector_light_shading_tb
  import svls_pkg::*;
();

  logic                  clk;
  logic                  rst;
  logic                  light_valid;
  logic                  light_stall;
  light_t                light;
  logic                  pixel_valid;
  logic                  pixel_stall;
  pixel_t                pixel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sprite_vector_light_shading u_dut (
    .clk         (clk),
    .rst         (rst),
    .light_valid (light_valid),
    .light_stall (light_stall),
    .light       (light),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // One directed row: the light beat, and a hand-typed pixel where the answer is obvious.
  typedef struct {
    light_t item;
    bit     typed;
    pixel_t want;
  } shade_row_t;

  // Shadow copy of the register file, reset values loaded here.
  longint nrm[3]       = '{0, 0, 16384};
  longint amb_floor[3] = '{0, 0, 0};
  longint alpha_q      = 16384;
  int     max_lights_q = 5;

  // Shadow copy of the per-sprite accumulators.
  longint amb_sum[3] = '{0, 0, 0};
  longint ext_sum[3] = '{0, 0, 0};
  int     taken      = 0;

  pixel_t     pending_pixels[$];
  shade_row_t shade_rows[$];

  int mismatches   = 0;
  int lights_sent  = 0;
  int pixels_seen  = 0;
  int reg_writes   = 0;
  bit send_gaps_on = 1'b1;
  bit recv_stall_on = 1'b1;
  int stall_left   = 0;

  // Clock: period 10, starts low.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // 255 * v / ONE after clamping v to [0, ONE], truncated.
  function automatic logic [7:0] byte_of(input longint v);
    longint c;
    c = clamp(v, 0, longint'(ONE_Q));
    return 8'((255 * c) >>> FRAC_BITS);
  endfunction

  // Advance the shading state by one light beat; flag and build the pixel on last_light.
  function automatic void shade_light(input light_t it, output bit emit, output pixel_t px);
    longint dirv[3];
    longint col[3];
    longint acc;
    longint s;
    longint gain;
    longint c;
    longint base;
    logic [7:0] ch[3];
    int limit;
    limit = (max_lights_q > MAX_LIGHT_LIMIT) ? MAX_LIGHT_LIMIT : max_lights_q;
    emit = 1'b0;
    px = '0;
    if (it.has_light && (limit == 0 || taken < limit)) begin
      dirv[0] = $signed(it.dir_x);
      dirv[1] = $signed(it.dir_y);
      dirv[2] = $signed(it.dir_z);
      col[0] = it.light_red;
      col[1] = it.light_green;
      col[2] = it.light_blue;
      acc = dirv[0] * nrm[0] + dirv[1] * nrm[1] + dirv[2] * nrm[2];
      s = (acc >>> FRAC_BITS) + longint'($signed(it.bias));
      // Zero strength counts as the dark side.
      gain = (s > 0) ? longint'($signed(it.lit_gain)) : longint'($signed(it.dark_gain));
      s = clamp((s * gain) >>> FRAC_BITS, -longint'(ONE_Q), longint'(ONE_Q));
      for (int i = 0; i < 3; i++) begin
        c = (col[i] * s) >>> FRAC_BITS;
        if (it.uses_ambient) begin
          amb_sum[i] = clamp(amb_sum[i] + c, SUM_MIN, SUM_MAX);
        end else begin
          ext_sum[i] = clamp(ext_sum[i] + c, SUM_MIN, SUM_MAX);
        end
      end
      if (taken < 15) begin
        taken++;
      end
    end
    if (it.last_light) begin
      for (int i = 0; i < 3; i++) begin
        base = (amb_sum[i] > amb_floor[i]) ? amb_sum[i] : amb_floor[i];
        ch[i] = byte_of(base + ext_sum[i]);
        amb_sum[i] = 0;
        ext_sum[i] = 0;
      end
      px = {ch[0], ch[1], ch[2], byte_of(alpha_q)};
      taken = 0;
      emit = 1'b1;
    end
  endfunction

  function automatic light_t mk_light(input bit has, input int dx, input int dy, input int dz,
                                      input int bias, input int lit, input int dark,
                                      input int r, input int g, input int b,
                                      input bit amb, input bit last);
    light_t it;
    it.has_light    = has;
    it.dir_x        = 16'(dx);
    it.dir_y        = 16'(dy);
    it.dir_z        = 16'(dz);
    it.bias         = 16'(bias);
    it.lit_gain     = 16'(lit);
    it.dark_gain    = 16'(dark);
    it.light_red    = 15'(r);
    it.light_green  = 15'(g);
    it.light_blue   = 15'(b);
    it.uses_ambient = amb;
    it.last_light   = last;
    return it;
  endfunction

  // Direction or normal component: mostly inside [-ONE, ONE], sometimes any 16-bit pattern.
  function automatic logic [15:0] rand_q1();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 16'(int'($urandom_range(0, 32768)) - 16384);
    if (roll < 85) return 16'h4000;
    if (roll < 90) return 16'hC000;
    return 16'($urandom());
  endfunction

  function automatic logic [14:0] rand_color();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 15'($urandom_range(0, 16384));
    if (roll < 85) return 15'd16384;
    if (roll < 90) return 15'd0;
    return 15'($urandom_range(0, 32767));
  endfunction

  function automatic logic [15:0] rand_gain();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 16'($urandom_range(0, 32767));
    if (roll < 68) return 16'h7FFF;
    if (roll < 75) return 16'h8000;
    return 16'($urandom());
  endfunction

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!send_gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one light beat after a gap, hold it until taken, then predict.
  task automatic send_light(input light_t item, input bit typed, input pixel_t want,
                            input int gap);
    bit emit;
    pixel_t px;
    if (gap > 0) begin
      @(negedge clk);
      light_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    light_valid <= 1'b1;
    light       <= item;
    do @(posedge clk); while (light_stall);
    shade_light(item, emit, px);
    if (emit) begin
      pending_pixels.push_back(typed ? want : px);
    end
    lights_sent++;
  endtask

  // Drop valid, wait out every pending pixel, then let the sequencer settle.
  task automatic wait_drain();
    @(negedge clk);
    light_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NORMAL_X:      nrm[0] = $signed(data);
      REG_NORMAL_Y:      nrm[1] = $signed(data);
      REG_NORMAL_Z:      nrm[2] = $signed(data);
      REG_AMBIENT_RED:   amb_floor[0] = data[14:0];
      REG_AMBIENT_GREEN: amb_floor[1] = data[14:0];
      REG_AMBIENT_BLUE:  amb_floor[2] = data[14:0];
      REG_AMBIENT_ALPHA: alpha_q = data[14:0];
      REG_MAX_LIGHTS:    max_lights_q = data[3:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a full register set for one phase: three fixed corner settings, then random ones.
  // Spare upper data bits are filled with junk; the block must ignore them.
  task automatic program_regs(input int phase);
    logic [15:0] nx, ny, nz;
    logic [14:0] ar, ag, ab, al;
    logic [3:0]  ml;
    case (phase)
      0: begin
        // Unlimited lights, alpha zero.
        nx = 16'hC000; ny = 16'h4000; nz = 16'h0000;
        ar = 15'd0; ag = 15'd16384; ab = 15'd16384; al = 15'd0; ml = 4'd0;
      end
      1: begin
        // Ambient and alpha above one, limit above the supported maximum.
        nx = 16'h4000; ny = 16'hC000; nz = 16'hC000;
        ar = 15'h7FFF; ag = 15'h7FFF; ab = 15'h7FFF; al = 15'h7FFF; ml = 4'd15;
      end
      2: begin
        // One light per sprite.
        nx = 16'h0000; ny = 16'h0000; nz = 16'h4000;
        ar = 15'd0; ag = 15'd0; ab = 15'd0; al = 15'd16384; ml = 4'd1;
      end
      default: begin
        nx = rand_q1(); ny = rand_q1(); nz = rand_q1();
        ar = rand_color(); ag = rand_color(); ab = rand_color(); al = rand_color();
        ml = 4'($urandom_range(0, 15));
      end
    endcase
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_AMBIENT_RED,   {1'($urandom_range(0, 1)), ar});
    write_reg(REG_AMBIENT_GREEN, {1'($urandom_range(0, 1)), ag});
    write_reg(REG_AMBIENT_BLUE,  {1'($urandom_range(0, 1)), ab});
    write_reg(REG_AMBIENT_ALPHA, {1'($urandom_range(0, 1)), al});
    write_reg(REG_MAX_LIGHTS,    {12'($urandom()), ml});
  endtask

  // Pixel-side stall: mostly open, short bursts, an occasional long hold.
  always @(negedge clk) begin : pixel_stall_gen
    int roll;
    if (!recv_stall_on) begin
      pixel_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pixel_stall <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        pixel_stall <= 1'b0;
      end else begin
        stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        pixel_stall <= 1'b1;
      end
    end
  end

  // Score every pixel beat against the oldest pending prediction.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel beat with none pending", pixel, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel.red_byte !== want.red_byte)
          report_mismatch("red_byte", pixel.red_byte, want.red_byte);
        if (pixel.green_byte !== want.green_byte)
          report_mismatch("green_byte", pixel.green_byte, want.green_byte);
        if (pixel.blue_byte !== want.blue_byte)
          report_mismatch("blue_byte", pixel.blue_byte, want.blue_byte);
        if (pixel.alpha_byte !== want.alpha_byte)
          report_mismatch("alpha_byte", pixel.alpha_byte, want.alpha_byte);
      end
    end
  end

  initial begin : stimulus
    light_t it;
    int len;
    int counted;
    bit paused;

    rst         = 1'b1;
    light_valid = 1'b0;
    light       = '0;
    pixel_stall = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    it          = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, all under the reset register values (normal along +z, limit 5).
    // Pixels read {red, green, blue, alpha}, red in the top byte.
    // Empty item closes an empty sprite: black, full alpha.
    shade_rows.push_back('{mk_light(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                           1'b1, pixel_t'(32'h0000_00FF)});
    // Light straight along the normal at unit gain and full color: white.
    shade_rows.push_back('{mk_light(1, 0, 0, 16384, 0, 16384, 0, 16384, 16384, 16384, 1, 1),
                           1'b1, pixel_t'(32'hFFFF_FFFF)});
    // Light from behind through the dark gain: negative sum, floored at zero ambient.
    shade_rows.push_back('{mk_light(1, 0, 0, -16384, 0, 0, 16384, 16384, 16384, 16384, 1, 1),
                           1'b1, pixel_t'(32'h0000_00FF)});
    // Empty item that does not end the sprite: no pixel.
    shade_rows.push_back('{mk_light(0, 123, -456, 789, -1, 5, -5, 100, 200, 300, 1, 0),
                           1'b0, '0});
    // Field extremes, both signs, both sums, colors beyond one.
    shade_rows.push_back('{mk_light(1, -16384, -16384, -16384, -32768, -32768, -32768,
                                    16384, 16384, 16384, 0, 0), 1'b0, '0});
    shade_rows.push_back('{mk_light(1, 16384, 16384, 16384, 32767, -32768, 32767,
                                    32767, 32767, 32767, 1, 0), 1'b0, '0});
    shade_rows.push_back('{mk_light(1, 0, 0, 0, 32767, 32767, 32767, 16384, 0, 32767, 0, 1),
                           1'b0, '0});
    // Tiny negative strength: floor rounding toward minus infinity.
    shade_rows.push_back('{mk_light(1, 0, 0, -1, 0, 0, 16384, 16384, 1, 0, 0, 1),
                           1'b0, '0});
    // Limit reached: five quarter-strength lights are taken, the sixth is dropped
    // but its last mark still closes the sprite.
    repeat (5) begin
      shade_rows.push_back('{mk_light(1, 0, 0, 16384, 0, 4096, 0, 16384, 8192, 0, 1, 0),
                             1'b0, '0});
    end
    shade_rows.push_back('{mk_light(1, 0, 0, -16384, 0, 0, 16384, 16384, 16384, 16384, 1, 1),
                           1'b1, pixel_t'(32'hFF9F_00FF)});
    // Smallest positive strength takes the lit gain.
    shade_rows.push_back('{mk_light(1, 0, 0, 0, 1, 16384, -16384, 16384, 16384, 16384, 1, 1),
                           1'b0, '0});

    foreach (shade_rows[i]) begin
      send_light(shade_rows[i].item, shade_rows[i].typed, shade_rows[i].want, pick_gap());
    end
    wait_drain();

    // Random phases: a fresh register set each, then well-formed sprites with random
    // content, salted with empty beats inside sprites and stray empty beats between.
    for (int phase = 0; phase < 8; phase++) begin
      send_gaps_on  = (phase != 2);
      recv_stall_on = (phase != 2);
      program_regs(phase);
      counted = 0;
      paused  = 1'b0;
      while (counted < 90) begin
        // Long sprites only matter with no limit, where the light count saturates.
        len = (max_lights_q == 0 && $urandom_range(0, 99) < 20) ?
              $urandom_range(14, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 8) begin
            // Stray beat with no light and no end mark: ignored by the block.
            it.has_light  = 1'b0;
            it.last_light = 1'b0;
            it.bias       = 16'($urandom());
            it.light_red  = 15'($urandom());
            send_light(it, 1'b0, '0, pick_gap());
          end
          it.has_light    = ($urandom_range(0, 99) < 92);
          it.dir_x        = rand_q1();
          it.dir_y        = rand_q1();
          it.dir_z        = rand_q1();
          it.bias         = ($urandom_range(0, 99) < 70) ?
                            16'(int'($urandom_range(0, 16384)) - 8192) : 16'($urandom());
          it.lit_gain     = rand_gain();
          it.dark_gain    = rand_gain();
          it.light_red    = rand_color();
          it.light_green  = rand_color();
          it.light_blue   = rand_color();
          it.uses_ambient = 1'($urandom_range(0, 1));
          it.last_light   = (k == len - 1);
          send_light(it, 1'b0, '0, pick_gap());
          counted++;
        end
        // Hold the sender once mid-phase until the pixel side has caught up.
        if (phase == 3 && !paused && counted >= 45) begin
          wait_drain();
          paused = 1'b1;
        end
      end
      wait_drain();
    end

    $display("sent %0d light beats, checked %0d pixels, %0d register writes",
             lights_sent, pixels_seen, reg_writes);
    $display("covered reset values, limits 0/1/over-range/random, ambient and alpha past one");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/svls_pkg.sv
hw/rtl/svls_mul.sv
hw/rtl/svls_ctrl.sv
hw/rtl/sprite_vector_light_shading.sv
tb/sv/sprite_vector_light_shading_tb.sv
